// ===== rtl/mcarw_pkg.sv =====
// ----------------------------------------------------------------------------
// mcarw_pkg
// Shared constants and types for the multi-channel anti-replay window.
// ----------------------------------------------------------------------------
package mcarw_pkg;

  localparam int WORD_BITS   = 64;
  localparam int WINDOW_BITS = 1024;
  localparam int WORDS       = WINDOW_BITS / WORD_BITS;
  localparam int CHANNELS    = 4;
  localparam int CH_W        = 2;
  localparam int SEQ_W       = 64;
  localparam int WIDX_W      = $clog2(WORDS);
  localparam int BS_W        = $clog2(WORD_BITS);
  localparam int DIST_W      = WIDX_W + BS_W;
  localparam int ADDR_W      = CH_W + WIDX_W;
  localparam int DEPTH       = CHANNELS * WORDS;
  localparam int RP_W        = WIDX_W + 2;

  localparam logic REQ_CHECK  = 1'b0;
  localparam logic REQ_COMMIT = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_neg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              clr_en;
    logic [CH_W-1:0]   clr_ch;
  } mem_cmd_t;

endpackage

// ===== rtl/mcarw_sub.sv =====
// ----------------------------------------------------------------------------
// mcarw_sub
// Shared 64-bit subtractor: difference and borrow (a < b).
// ----------------------------------------------------------------------------
module mcarw_sub (
  input  logic [mcarw_pkg::SEQ_W-1:0] a,
  input  logic [mcarw_pkg::SEQ_W-1:0] b,
  output logic [mcarw_pkg::SEQ_W-1:0] diff,
  output logic                        borrow
);
  import mcarw_pkg::*;

  logic [SEQ_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[SEQ_W-1:0];
  assign borrow = full[SEQ_W];

endmodule

// ===== rtl/mcarw_funnel.sv =====
// ----------------------------------------------------------------------------
// mcarw_funnel
// Window word funnel shifter: joins a word with the bits carried up from the
// word below it, optionally marking distance zero.
// ----------------------------------------------------------------------------
module mcarw_funnel (
  input  mcarw_pkg::word_t             hi,
  input  mcarw_pkg::word_t             lo,
  input  logic [mcarw_pkg::BS_W-1:0]   bs,
  input  logic                         set_lsb,
  output mcarw_pkg::word_t             y
);
  import mcarw_pkg::*;

  logic [BS_W:0] rsh;
  word_t         carry;

  assign rsh   = (BS_W+1)'(WORD_BITS) - {1'b0, bs};
  assign carry = (bs == '0) ? '0 : (lo >> rsh);
  assign y     = (hi << bs) | carry | {{(WORD_BITS-1){1'b0}}, set_lsb};

endmodule

// ===== rtl/mcarw_win_mem.sv =====
// ----------------------------------------------------------------------------
// mcarw_win_mem
// Window bitmap memory, one word per address, with per-word valid bits so a
// channel's window clears by a single command. Invalid words read as zero.
// ----------------------------------------------------------------------------
module mcarw_win_mem (
  input  logic                 clk,
  input  logic                 rst,
  input  mcarw_pkg::mem_cmd_t  cmd,
  input  mcarw_pkg::word_t     wr_data,
  output mcarw_pkg::word_t     rd_word
);
  import mcarw_pkg::*;

  word_t            mem [DEPTH];
  word_t            mem_q;
  logic [DEPTH-1:0] wv;
  logic             vq;
  logic             neg_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    mem_q <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wv    <= '0;
      vq    <= 1'b0;
      neg_q <= 1'b1;
    end else begin
      vq    <= wv[cmd.rd_addr];
      neg_q <= cmd.rd_neg;
      for (int i = 0; i < DEPTH; i++) begin
        if (cmd.clr_en && (ADDR_W'(i) >> WIDX_W) == ADDR_W'(cmd.clr_ch)) begin
          wv[i] <= 1'b0;
        end
      end
      if (cmd.wr_en) begin
        wv[cmd.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_word = (neg_q || !vq) ? '0 : mem_q;

endmodule

// ===== rtl/multi_channel_anti_replay_window.sv =====
// ----------------------------------------------------------------------------
// multi_channel_anti_replay_window
// Four-channel sliding-window replay filter: check or commit a sequence
// number against each channel's top and 1024-bit seen window.
// ----------------------------------------------------------------------------
// Channel   Handshake               Beat
// request   start / busy            req_type, channel, seq
// result    done (strobe)           allowed
// config    cfg_valid / cfg_ready   cfg_data (seq_limit)
//
// S_DIFF, then check: S_LIM, S_BIT; older commit: S_OLD (S_RMW if in window);
// first commit: S_INIT; newer commit: S_FWD, then S_INIT if the jump clears the
// window, else S_PRE0, S_PRE1, S_SHIFT: the window slides one word per cycle,
// each word read from and written back to window memory. busy stays high until
// done; done lasts one cycle and cannot be stalled. Reset clears all channels.
// ----------------------------------------------------------------------------
module multi_channel_anti_replay_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type,
  input  logic [mcarw_pkg::CH_W-1:0]   channel,
  input  logic [mcarw_pkg::SEQ_W-1:0]  seq,
  output logic                         done,
  output logic                         allowed,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mcarw_pkg::SEQ_W-1:0]  cfg_data
);
  import mcarw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_LIM, S_BIT, S_INIT, S_FWD,
    S_PRE0, S_PRE1, S_SHIFT, S_OLD, S_RMW
  } state_t;

  state_t              state;
  logic                req_r;
  logic [CH_W-1:0]     ch_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [SEQ_W-1:0]    diff_r;
  logic                newer_r;
  logic                lim_ok;
  logic [BS_W-1:0]     bs_r;
  logic [WIDX_W-1:0]   k;
  logic [RP_W-1:0]     rp;
  word_t               cur;
  logic [SEQ_W-1:0]    seq_limit;
  logic [CHANNELS-1:0] chan_valid;
  logic [SEQ_W-1:0]    top_seq [CHANNELS];

  logic [SEQ_W-1:0]    sub_a, sub_b, sub_d;
  logic                sub_borrow;
  logic [SEQ_W-1:0]    top_cur;
  mem_cmd_t            cmd;
  word_t               wr_data, rd_word, fun_y;
  logic                in_win;

  assign top_cur   = top_seq[ch_r];
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_win    = (diff_r[SEQ_W-1:DIST_W] == '0);

  always_comb begin
    case (state)
      S_LIM: begin
        sub_a = seq_r;
        sub_b = seq_limit;
      end
      S_FWD: begin
        sub_a = seq_r;
        sub_b = top_cur;
      end
      default: begin
        sub_a = top_cur;
        sub_b = seq_r;
      end
    endcase
  end

  mcarw_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_d),
    .borrow (sub_borrow)
  );

  mcarw_funnel u_funnel (
    .hi      (cur),
    .lo      (rd_word),
    .bs      (bs_r),
    .set_lsb (k == '0),
    .y       (fun_y)
  );

  always_comb begin
    cmd         = '0;
    cmd.rd_addr = {ch_r, rp[WIDX_W-1:0]};
    cmd.rd_neg  = rp[RP_W-1];
    cmd.clr_ch  = ch_r;
    wr_data     = fun_y;
    case (state)
      S_LIM, S_OLD: begin
        cmd.rd_addr = {ch_r, diff_r[DIST_W-1:BS_W]};
        cmd.rd_neg  = 1'b0;
      end
      S_INIT: begin
        cmd.clr_en  = 1'b1;
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = {ch_r, {WIDX_W{1'b0}}};
        wr_data     = word_t'(1);
      end
      S_SHIFT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = {ch_r, k};
      end
      S_RMW: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = {ch_r, diff_r[DIST_W-1:BS_W]};
        wr_data     = rd_word | (word_t'(1) << diff_r[BS_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  mcarw_win_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .wr_data (wr_data),
    .rd_word (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      allowed    <= 1'b0;
      seq_limit  <= '1;
      chan_valid <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        top_seq[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        seq_limit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req_r <= req_type;
            ch_r  <= channel;
            seq_r <= seq;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_r  <= sub_d;
          newer_r <= sub_borrow;
          if (req_r == REQ_CHECK) begin
            state <= S_LIM;
          end else if (!chan_valid[ch_r]) begin
            state <= S_INIT;
          end else if (sub_borrow) begin
            state <= S_FWD;
          end else begin
            state <= S_OLD;
          end
        end
        S_LIM: begin
          lim_ok <= sub_borrow;
          state  <= S_BIT;
        end
        S_BIT: begin
          allowed <= lim_ok && (!chan_valid[ch_r] || newer_r ||
                     (in_win && !rd_word[diff_r[BS_W-1:0]]));
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        S_INIT: begin
          chan_valid[ch_r] <= 1'b1;
          top_seq[ch_r]    <= seq_r;
          allowed          <= 1'b1;
          done             <= 1'b1;
          state            <= S_IDLE;
        end
        S_FWD: begin
          top_seq[ch_r] <= seq_r;
          bs_r          <= sub_d[BS_W-1:0];
          k             <= WIDX_W'(WORDS - 1);
          rp            <= RP_W'(WORDS - 1) - RP_W'(sub_d[DIST_W-1:BS_W]);
          if (sub_d[SEQ_W-1:DIST_W] != '0) begin
            state <= S_INIT;
          end else begin
            state <= S_PRE0;
          end
        end
        S_PRE0: begin
          rp    <= rp - RP_W'(1);
          state <= S_PRE1;
        end
        S_PRE1: begin
          cur   <= rd_word;
          rp    <= rp - RP_W'(1);
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          cur <= rd_word;
          rp  <= rp - RP_W'(1);
          k   <= k - WIDX_W'(1);
          if (k == '0) begin
            allowed <= 1'b1;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_OLD: begin
          if (in_win) begin
            state <= S_RMW;
          end else begin
            allowed <= 1'b1;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_RMW: begin
          allowed <= 1'b1;
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for two cycles");

  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    done && req_r == REQ_COMMIT |-> allowed)
    else $error("commit answered not allowed");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result given while still busy");

endmodule
